// File: design/knn_connectivity_index_core_assert.svh
// Assertion macros for the k-nearest-neighbour connectivity index core.
// Included by the top level; the bodies expect aclk and aresetn in scope.
// Assertions are compiled out when SYNTHESIS is defined.
`ifndef KNN_CONNECTIVITY_INDEX_CORE_ASSERT_SVH
`define KNN_CONNECTIVITY_INDEX_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Condition in this cycle implies consequence in the same cycle.
`define KNN_CI_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Condition in this cycle implies consequence in the next cycle.
`define KNN_CI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define KNN_CI_ASSERT_SAME(lbl, ante, cons, msg)
`define KNN_CI_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: design/knn_ci_pkg.sv
// Shared constants, types and command struct for the connectivity index core.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package knn_ci_pkg;

    // Sizing of the neighbour list and label comparison.
    localparam int MAX_NEIGHBOURS = 16;
    localparam int LABEL_BITS     = 8;

    // Fixed widths of the interface fields.
    localparam int DIST_W    = 16;
    localparam int INDEX_W   = 10;
    localparam int CLUSTER_W = 8;
    localparam int TOTAL_W   = 28;
    localparam int FRAC_W    = 16;
    localparam int TERM_W    = FRAC_W + 1;
    localparam int FRAC_ONE  = 1 << FRAC_W;

    localparam int LABEL_W = (LABEL_BITS < CLUSTER_W) ? LABEL_BITS : CLUSTER_W;
    localparam int CNT_W   = $clog2(MAX_NEIGHBOURS + 1);
    localparam int SLOT_W  = (MAX_NEIGHBOURS > 1) ? $clog2(MAX_NEIGHBOURS) : 1;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    // Configuration port.
    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 3;
    localparam int CFG_IDX_W  = PADDR_W - 2;
    localparam int NCOUNT_W   = 5;
    localparam logic [NCOUNT_W-1:0]  NCOUNT_RESET        = NCOUNT_W'(10);
    localparam logic [CFG_IDX_W-1:0] REG_NEIGHBOUR_COUNT = CFG_IDX_W'(0);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLOSE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic              accept;
        logic              close_step;
        logic              clear_list;
        logic              emit;
        logic [SLOT_W-1:0] slot;
    } dp_cmd_t;

endpackage

`default_nettype wire

// File: design/knn_ci_ctrl.sv
// Controller state machine: accepts entries, steps the row close over the
// neighbour slots and hands the total to the output register. Uses knn_ci_pkg.
`default_nettype none

module knn_ci_ctrl
    import knn_ci_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic             s_last_in_row,
    input  wire logic             s_last_of_matrix,
    output logic                  m_valid,
    input  wire logic             m_ready,
    input  wire logic [CNT_W-1:0] count,
    output dp_cmd_t               cmd
);

    state_t            state_reg, state_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              mat_pend_reg, mat_pend_next;
    logic              out_valid_reg, out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            slot_reg      <= '0;
            mat_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            mat_pend_reg  <= mat_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        slot_next      = slot_reg;
        mat_pend_next  = mat_pend_reg;
        out_valid_next = out_valid_reg && !m_ready;
        s_ready        = 1'b0;
        cmd            = '0;
        cmd.slot       = slot_reg;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    if (s_last_in_row || s_last_of_matrix) begin
                        state_next    = ST_CLOSE;
                        slot_next     = '0;
                        mat_pend_next = s_last_of_matrix;
                    end
                end
            end
            ST_CLOSE: begin
                cmd.close_step = 1'b1;
                if (CNT_W'(slot_reg) == CNT_W'(count - 1'b1)) begin
                    cmd.clear_list = 1'b1;
                    state_next     = mat_pend_reg ? ST_EMIT : ST_IDLE;
                end else begin
                    slot_next = SLOT_W'(slot_reg + 1'b1);
                end
            end
            ST_EMIT: begin
                // The output register must be free, or freed in this cycle.
                if (!out_valid_reg || m_ready) begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid = out_valid_reg;

endmodule

`default_nettype wire

// File: design/knn_ci_datapath.sv
// Datapath: sorted neighbour list with compare-and-shift insertion, the
// reciprocal-rank accumulator and the output register. Uses knn_ci_pkg.
`default_nettype none

module knn_ci_datapath
    import knn_ci_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire dp_cmd_t              cmd,
    input  wire logic [CNT_W-1:0]     count,
    input  wire logic [DIST_W-1:0]    s_dissimilarity,
    input  wire logic [INDEX_W-1:0]   s_row_index,
    input  wire logic [INDEX_W-1:0]   s_col_index,
    input  wire logic [CLUSTER_W-1:0] s_row_cluster,
    input  wire logic [CLUSTER_W-1:0] s_col_cluster,
    output logic [TOTAL_W-1:0]        m_connectivity
);

    logic [DIST_W-1:0]  dist_reg  [MAX_NEIGHBOURS];
    logic [DIST_W-1:0]  dist_next [MAX_NEIGHBOURS];
    logic [LABEL_W-1:0] label_reg [MAX_NEIGHBOURS];
    logic [LABEL_W-1:0] label_next[MAX_NEIGHBOURS];
    logic               valid_reg [MAX_NEIGHBOURS];
    logic               valid_next[MAX_NEIGHBOURS];
    logic               keeps     [MAX_NEIGHBOURS];
    logic [TERM_W-1:0]  term_table[MAX_NEIGHBOURS];

    logic [LABEL_W-1:0] row_label_reg, row_label_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [TOTAL_W-1:0] out_reg, out_next;

    logic               do_insert;
    logic [LABEL_W-1:0] new_label;
    logic [TOTAL_W:0]   sum;

    assign do_insert = cmd.accept && (s_row_index != s_col_index);
    assign new_label = s_col_cluster[LABEL_W-1:0];

    // Each slot keeps its entry when it is filled and not farther than the
    // new distance; equal distances keep the earlier column in front.
    for (genvar k = 0; k < MAX_NEIGHBOURS; k++) begin : g_slot
        localparam logic [TERM_W-1:0] TERM =
            TERM_W'((FRAC_ONE + (k + 1) / 2) / (k + 1));
        logic in_range;
        logic take_new;

        assign term_table[k] = TERM;
        assign keeps[k]      = valid_reg[k] && (dist_reg[k] <= s_dissimilarity);
        assign in_range      = CNT_W'(k) < count;

        if (k == 0) begin : g_head
            assign take_new = 1'b1;
        end else begin : g_body
            assign take_new = keeps[k-1];
        end

        always_comb begin
            dist_next[k]  = dist_reg[k];
            label_next[k] = label_reg[k];
            valid_next[k] = valid_reg[k];
            if (cmd.clear_list) begin
                valid_next[k] = 1'b0;
            end else if (do_insert && in_range && !keeps[k]) begin
                if (take_new) begin
                    dist_next[k]  = s_dissimilarity;
                    label_next[k] = new_label;
                    valid_next[k] = 1'b1;
                end else if (k > 0) begin
                    dist_next[k]  = dist_reg[(k > 0) ? k - 1 : 0];
                    label_next[k] = label_reg[(k > 0) ? k - 1 : 0];
                    valid_next[k] = valid_reg[(k > 0) ? k - 1 : 0];
                end
            end
        end
    end

    always_comb begin
        row_label_next = row_label_reg;
        total_next     = total_reg;
        out_next       = out_reg;
        sum            = {1'b0, total_reg} + (TOTAL_W + 1)'(term_table[cmd.slot]);
        if (cmd.accept) begin
            row_label_next = s_row_cluster[LABEL_W-1:0];
        end
        if (cmd.close_step && valid_reg[cmd.slot]
                && (label_reg[cmd.slot] != row_label_reg)) begin
            total_next = (sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum[TOTAL_W-1:0];
        end
        if (cmd.emit) begin
            out_next   = total_reg;
            total_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= '0;
            for (int i = 0; i < MAX_NEIGHBOURS; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else begin
            total_reg <= total_next;
            for (int i = 0; i < MAX_NEIGHBOURS; i++) begin
                valid_reg[i] <= valid_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        row_label_reg <= row_label_next;
        out_reg       <= out_next;
        for (int i = 0; i < MAX_NEIGHBOURS; i++) begin
            dist_reg[i]  <= dist_next[i];
            label_reg[i] <= label_next[i];
        end
    end

    assign m_connectivity = out_reg;

endmodule

`default_nettype wire

// File: design/knn_connectivity_index_core.sv
// Top level of the k-nearest-neighbour cluster connectivity index core.
// Holds the configuration register and joins knn_ci_ctrl and knn_ci_datapath;
// uses knn_ci_pkg and knn_connectivity_index_core_assert.svh.
//
//   Channel  Direction  Handshake          Carries
//   s_*      in         s_valid/s_ready    one dissimilarity matrix entry
//   m_*      out        m_valid/m_ready    connectivity total, Q12.16
//   APB      in         psel/penable       neighbour_count at address 0
//
// An entry without a row or matrix mark is inserted into the sorted list by a
// parallel compare-and-shift at the transfer edge and does not hold up the next.
// An entry that ends a row steps the close over the list slot by slot, through
// the single accumulator adder; one that ends the matrix then hands the total to
// the output register, waiting there while that register is still full.
// Reset clears the list's valid bits, the total and all control state at once.
// A result waiting on m_ready does not stop entries of the next matrix.
`default_nettype none
`include "knn_connectivity_index_core_assert.svh"

module knn_connectivity_index_core
    import knn_ci_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [DIST_W-1:0]     s_dissimilarity,
    input  wire logic [INDEX_W-1:0]    s_row_index,
    input  wire logic [INDEX_W-1:0]    s_col_index,
    input  wire logic [CLUSTER_W-1:0]  s_row_cluster,
    input  wire logic [CLUSTER_W-1:0]  s_col_cluster,
    input  wire logic                  s_last_in_row,
    input  wire logic                  s_last_of_matrix,

    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [TOTAL_W-1:0]         m_connectivity,

    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [PADDR_W-1:0]    paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready
);

    logic [NCOUNT_W-1:0]  neighbour_count_reg, neighbour_count_next;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [CNT_W-1:0]     count;
    dp_cmd_t              cmd;

    // The register sits at byte address zero; the word index selects it.
    assign reg_index = paddr[PADDR_W-1:2];
    assign pready    = 1'b1;

    always_comb begin
        neighbour_count_next = neighbour_count_reg;
        if (psel && penable && pwrite && (reg_index == REG_NEIGHBOUR_COUNT)) begin
            neighbour_count_next = pwdata[NCOUNT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            neighbour_count_reg <= NCOUNT_RESET;
        end else begin
            neighbour_count_reg <= neighbour_count_next;
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_index == REG_NEIGHBOUR_COUNT) begin
            prdata = APB_DATA_W'(neighbour_count_reg);
        end
    end

    // A count of zero behaves as one, and anything above the list length as
    // the full list.
    always_comb begin
        if (neighbour_count_reg == '0) begin
            count = CNT_W'(1);
        end else if (32'(neighbour_count_reg) > MAX_NEIGHBOURS) begin
            count = CNT_W'(MAX_NEIGHBOURS);
        end else begin
            count = CNT_W'(neighbour_count_reg);
        end
    end

    knn_ci_ctrl u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_last_in_row    (s_last_in_row),
        .s_last_of_matrix (s_last_of_matrix),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .count            (count),
        .cmd              (cmd)
    );

    knn_ci_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .count           (count),
        .s_dissimilarity (s_dissimilarity),
        .s_row_index     (s_row_index),
        .s_col_index     (s_col_index),
        .s_row_cluster   (s_row_cluster),
        .s_col_cluster   (s_col_cluster),
        .m_connectivity  (m_connectivity)
    );

    // A transfer that ends a row starts the close, so no entry can follow at once.
    `KNN_CI_ASSERT_NEXT(a_row_end_stalls, s_valid && s_ready && (s_last_in_row || s_last_of_matrix), !s_ready, "entry accepted directly after a row end")

    // A plain entry never holds up the next one.
    `KNN_CI_ASSERT_NEXT(a_plain_entry_streams, s_valid && s_ready && !s_last_in_row && !s_last_of_matrix, s_ready, "input stalled after a plain entry")

    // The accumulator is never stepped while entries can still arrive.
    `KNN_CI_ASSERT_SAME(a_close_excludes_accept, cmd.close_step || cmd.emit, !s_ready && !cmd.accept, "row close overlaps an input transfer")

endmodule

`default_nettype wire
